// ===== hdl/sfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_pkg
// Shared types and constants of the scan frame ping-pong assembler.
// ----------------------------------------------------------------------------
package sfpa_pkg;

    // Samples per frame
    localparam int FRAME_LEN = 10;

    // Field widths
    localparam int ANGLE_W = 22;
    localparam int RANGE_W = 16;
    localparam int SLOT_W  = 6;

    // Store geometry: two banks of FRAME_LEN entries
    localparam int DEPTH  = 2 * FRAME_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(FRAME_LEN);

    typedef logic [ANGLE_W-1:0] t_angle;
    typedef logic [RANGE_W-1:0] t_range;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CNT_W-1:0]   t_cnt;

    // Index of the final slot of a frame
    localparam t_cnt LAST_IDX = CNT_W'(FRAME_LEN - 1);

    // Input beat
    typedef struct packed {
        t_angle scan_angle;
        t_range range_sample;
    } t_in_item;

    // Output beat
    typedef struct packed {
        t_range     range_out;
        t_slot      slot_index;
        t_angle     frame_start_angle;
        t_angle     frame_stop_angle;
        logic       frame_last;
    } t_out_item;

    // Store write port
    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_range data;
    } t_wr_port;

    // Store read port
    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_rd_port;

    // Frame hand-over from fill side to emitter
    typedef struct packed {
        logic   go;
        logic   bank;
        t_angle a_first;
        t_angle a_last;
    } t_frame_start;

    // Base address of a bank plus an offset within it
    function automatic t_addr bank_addr(input logic bank, input t_cnt idx);
        t_addr base;
        base = bank ? t_addr'(FRAME_LEN) : t_addr'(0);
        return base + t_addr'(idx);
    endfunction

endpackage

// ===== hdl/sfpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module sfpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/sfpa_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_fill
// Fill side: writes each sample's distance into the current bank, keeps the
// frame's first angle and hands a full bank over to the emitter.
// ----------------------------------------------------------------------------
module sfpa_fill (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  sfpa_pkg::t_in_item     i_item,
    input  logic                   i_em_busy,
    output sfpa_pkg::t_wr_port     o_wr,
    output sfpa_pkg::t_frame_start o_start
);

    logic            r_bank;
    logic            n_bank;
    sfpa_pkg::t_cnt   r_cnt;
    sfpa_pkg::t_cnt   n_cnt;
    sfpa_pkg::t_angle r_first;
    logic            accept;
    logic            frame_end;

    // Hold off the closing beat of a frame while the other bank still drains
    assign o_stall   = i_em_busy && (r_cnt == sfpa_pkg::LAST_IDX);
    assign accept    = i_valid && !o_stall;
    assign frame_end = accept && (r_cnt == sfpa_pkg::LAST_IDX);

    // Slot counter and bank select
    always_comb begin
        n_cnt  = r_cnt;
        n_bank = r_bank;
        if (accept) begin
            if (r_cnt == sfpa_pkg::LAST_IDX) begin
                n_cnt  = '0;
                n_bank = ~r_bank;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bank <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_bank <= n_bank;
        end
    end

    // First angle of the frame
    always_ff @(posedge i_clk) begin
        if (accept && (r_cnt == '0)) begin
            r_first <= i_item.scan_angle;
        end
    end

    // Store write
    assign o_wr.en   = accept;
    assign o_wr.addr = sfpa_pkg::bank_addr(r_bank, r_cnt);
    assign o_wr.data = i_item.range_sample;

    // Hand-over of the completed bank
    assign o_start.go      = frame_end;
    assign o_start.bank    = r_bank;
    assign o_start.a_first = r_first;
    assign o_start.a_last  = i_item.scan_angle;

    // Counter wraps after the closing beat
    a_cnt_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> (r_cnt == '0))
        else $error("fill count did not wrap after frame end");

    // Bank flips exactly at frame end
    a_bank_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> (r_bank != $past(r_bank)))
        else $error("bank did not swap at frame end");

    // No hand-over while the emitter is still draining
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |-> !i_em_busy)
        else $error("frame handed over to busy emitter");

endmodule

// ===== hdl/sfpa_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_emit
// Emitter: reads a full bank out of the store, forward or reversed, one slot
// per beat. The store's read register doubles as the output register.
// ----------------------------------------------------------------------------
module sfpa_emit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfpa_pkg::t_frame_start i_start,
    output logic                   o_busy,
    output sfpa_pkg::t_rd_port     o_rd,
    input  sfpa_pkg::t_range       i_rd_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output sfpa_pkg::t_out_item    o_res
);

    logic             r_busy;
    logic             n_busy;
    logic             r_out_vld;
    logic             n_out_vld;
    sfpa_pkg::t_cnt   r_k;
    sfpa_pkg::t_cnt   n_k;
    logic             r_bank;
    logic             r_rev;
    sfpa_pkg::t_angle r_a_lo;
    sfpa_pkg::t_angle r_a_hi;
    sfpa_pkg::t_slot  r_out_slot;
    sfpa_pkg::t_angle r_out_lo;
    sfpa_pkg::t_angle r_out_hi;
    logic             r_out_last;
    logic             issue;
    logic             rev_in;
    sfpa_pkg::t_cnt   src;

    // While busy, a read is issued whenever the output stage is free or being taken
    assign issue  = r_busy && (!r_out_vld || !i_stall);
    assign rev_in = i_start.a_first > i_start.a_last;
    assign src    = r_rev ? (sfpa_pkg::LAST_IDX - r_k) : r_k;

    assign o_rd.en   = issue;
    assign o_rd.addr = sfpa_pkg::bank_addr(r_bank, src);

    // Control
    always_comb begin
        n_busy    = r_busy;
        n_k       = r_k;
        n_out_vld = r_out_vld;
        if (issue) begin
            n_out_vld = 1'b1;
            n_k       = r_k + 1'b1;
            if (r_k == sfpa_pkg::LAST_IDX) begin
                n_busy = 1'b0;
            end
        end else if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        if (i_start.go) begin
            n_busy = 1'b1;
            n_k    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_k       <= n_k;
            r_out_vld <= n_out_vld;
        end
    end

    // Frame context, sorted so that start <= stop
    always_ff @(posedge i_clk) begin
        if (i_start.go) begin
            r_bank <= i_start.bank;
            r_rev  <= rev_in;
            r_a_lo <= rev_in ? i_start.a_last  : i_start.a_first;
            r_a_hi <= rev_in ? i_start.a_first : i_start.a_last;
        end
    end

    // Sideband of the output beat, loaded alongside the read data
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_slot <= sfpa_pkg::t_slot'(r_k);
            r_out_lo   <= r_a_lo;
            r_out_hi   <= r_a_hi;
            r_out_last <= (r_k == sfpa_pkg::LAST_IDX);
        end
    end

    assign o_busy                  = r_busy;
    assign o_valid                 = r_out_vld;
    assign o_res.range_out         = i_rd_data;
    assign o_res.slot_index        = r_out_slot;
    assign o_res.frame_start_angle = r_out_lo;
    assign o_res.frame_stop_angle  = r_out_hi;
    assign o_res.frame_last        = r_out_last;

    // Slot counter stays inside the frame
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k <= sfpa_pkg::LAST_IDX))
        else $error("emit slot counter out of range");

    // Emitter goes idle right after the final slot is read
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && (r_k == sfpa_pkg::LAST_IDX) && !i_start.go) |=> !r_busy)
        else $error("emitter still busy after final slot");

    // Beats carry ordered angles
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_lo <= r_out_hi))
        else $error("frame start angle above stop angle");

endmodule

// ===== hdl/scan_frame_pingpong_assembler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_frame_pingpong_assembler_core
// Collects (angle, distance) samples into frames in a two-bank store and
// emits each full frame in ascending angle order.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_item): one sample per beat. Its
// distance goes to the next slot of the current fill bank.
// Output channel (o_valid / i_stall / o_res): after every FRAME_LEN samples
// the full bank is read out as FRAME_LEN beats, slot_index 0 upwards, with
// frame_last on the final beat. Distances are reversed and angles swapped
// when the first angle exceeds the last.
// Readout: once the closing sample is taken the emitter goes busy and issues
// store reads, one beat per cycle while i_stall is low; each beat is one store read.
// Throughput: one sample per cycle within a frame. Filling one bank overlaps
// the readout of the other; o_stall rises only on the closing sample of a
// frame while reads of the previous frame are still being issued. The last
// read overlaps that sample's cycle, so in a steady stream with a free
// receiver the closing sample of each frame stalls while that read is issued.
// Reset: fill count and bank select clear, no frame pending; store contents
// are not cleared. A stalled receiver holds the current beat and the
// emitter issues no further reads until it is taken.
// ----------------------------------------------------------------------------
module scan_frame_pingpong_assembler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sfpa_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output sfpa_pkg::t_out_item o_res
);

    sfpa_pkg::t_wr_port     wr;
    sfpa_pkg::t_rd_port     rd;
    sfpa_pkg::t_frame_start start;
    sfpa_pkg::t_range       rd_data;
    logic                   em_busy;

    // Fill side
    sfpa_fill u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .i_em_busy (em_busy),
        .o_wr      (wr),
        .o_start   (start)
    );

    // Two-bank sample store
    sfpa_ram #(
        .WIDTH (sfpa_pkg::RANGE_W),
        .DEPTH (sfpa_pkg::DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd.en),
        .i_rd_addr (rd.addr),
        .o_rd_data (rd_data)
    );

    // Frame readout
    sfpa_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (em_busy),
        .o_rd      (rd),
        .i_rd_data (rd_data),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (o_res)
    );

endmodule

// ===== tb/tb_scan_frame_pingpong_assembler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scan_frame_pingpong_assembler_core
// Self-checking bench for the ping-pong frame assembler. Samples are pushed
// in as whole sweeps (rising, falling, flat, scattered) mixed with broken
// runs. A software copy of the two banks predicts every frame beat, including
// the reversal of falling sweeps. Both channels see random idle bursts. The
// sender pauses for the store to drain, and a closing phase runs flat out.
// ----------------------------------------------------------------------------
module tb_scan_frame_pingpong_assembler_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 60;
    localparam sfpa_pkg::t_angle ANGLE_TOP = sfpa_pkg::t_angle'(3600000);

    // Kinds of sweep used to build a frame
    typedef enum int {
        SWEEP_UP,
        SWEEP_DOWN,
        SWEEP_FLAT,
        SWEEP_NOISE
    } t_sweep;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    sfpa_pkg::t_in_item  i_item  = '0;
    logic                o_stall;
    logic                o_valid;
    sfpa_pkg::t_out_item o_res;

    // Idle burst enables, sender and receiver
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    int samples_sent = 0;
    int err_count    = 0;

    // Shadow of the two banks
    sfpa_pkg::t_range    held_ranges[2][sfpa_pkg::FRAME_LEN];
    sfpa_pkg::t_angle    bank_first_angle[2];
    logic                fill_bank = 1'b0;
    int                  fill_cnt  = 0;
    sfpa_pkg::t_out_item frame_beats_q[$];

    scan_frame_pingpong_assembler_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Store one sample; on a full bank, queue the whole frame it closes
    function automatic void predict_frame_beats(input sfpa_pkg::t_in_item smp);
        logic                closing_bank;
        sfpa_pkg::t_angle    a_open;
        logic                flip;
        int                  k;
        int                  src;
        sfpa_pkg::t_out_item beat;
        if (fill_cnt == 0) begin
            bank_first_angle[fill_bank] = smp.scan_angle;
        end
        held_ranges[fill_bank][fill_cnt] = smp.range_sample;
        fill_cnt++;
        if (fill_cnt < sfpa_pkg::FRAME_LEN) begin
            return;
        end
        fill_cnt     = 0;
        closing_bank = fill_bank;
        fill_bank    = ~fill_bank;
        a_open       = bank_first_angle[closing_bank];
        flip         = a_open > smp.scan_angle;
        for (k = 0; k < sfpa_pkg::FRAME_LEN; k++) begin
            src                    = flip ? sfpa_pkg::FRAME_LEN - 1 - k : k;
            beat.range_out         = held_ranges[closing_bank][src];
            beat.slot_index        = sfpa_pkg::t_slot'(k);
            beat.frame_start_angle = flip ? smp.scan_angle : a_open;
            beat.frame_stop_angle  = flip ? a_open : smp.scan_angle;
            beat.frame_last        = (k == sfpa_pkg::FRAME_LEN - 1);
            frame_beats_q.push_back(beat);
        end
    endfunction

    function automatic sfpa_pkg::t_angle rand_angle();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ANGLE_TOP;
            2:       return sfpa_pkg::t_angle'($urandom);
            default: return sfpa_pkg::t_angle'($urandom_range(0, 3600000));
        endcase
    endfunction

    function automatic sfpa_pkg::t_range rand_range();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return sfpa_pkg::t_range'($urandom);
        endcase
    endfunction

    // Drive one sample beat and hold it until taken; called just after an edge
    task automatic send_sample(input sfpa_pkg::t_angle angle,
                               input sfpa_pkg::t_range range);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{scan_angle: angle, range_sample: range};
        do @(posedge i_clk); while (o_stall);
        predict_frame_beats('{scan_angle: angle, range_sample: range});
        samples_sent++;
    endtask

    // Hold the sender off until every predicted beat has come out
    task automatic wait_frames_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (frame_beats_q.size() != 0);
    endtask

    // Complete the frame now filling, shaped as the given sweep
    task automatic send_frame(input t_sweep kind);
        sfpa_pkg::t_angle lo, hi, a_first, a_last, swap;
        bit               fresh;
        int               n, k;
        lo = rand_angle();
        hi = rand_angle();
        if (lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        if (lo == hi) begin
            if (hi != '1) hi++;
            else lo--;
        end
        case (kind)
            SWEEP_UP: begin
                a_first = lo;
                a_last  = hi;
            end
            SWEEP_DOWN: begin
                a_first = hi;
                a_last  = lo;
            end
            SWEEP_FLAT: begin
                a_first = lo;
                a_last  = lo;
            end
            default: begin
                a_first = rand_angle();
                a_last  = rand_angle();
            end
        endcase
        fresh = (fill_cnt == 0);
        n     = sfpa_pkg::FRAME_LEN - fill_cnt;
        for (k = 0; k < n; k++) begin
            if (k == 0 && fresh) send_sample(a_first, rand_range());
            else if (k == n - 1) send_sample(a_last, rand_range());
            else send_sample(sfpa_pkg::t_angle'($urandom_range(lo, hi)), rand_range());
        end
    endtask

    // A broken run of fewer samples than a frame that can leave the frame misaligned
    task automatic send_noise();
        int n;
        n = $urandom_range(1, sfpa_pkg::FRAME_LEN - 1);
        repeat (n) send_sample(rand_angle(), rand_range());
    endtask

    // Rising, falling and flat sweeps with extreme angles and distances
    task automatic test_directed_sweeps();
        int k;
        for (k = 0; k < sfpa_pkg::FRAME_LEN; k++) begin
            send_sample((k == sfpa_pkg::FRAME_LEN - 1) ? sfpa_pkg::t_angle'('1)
                                                       : sfpa_pkg::t_angle'(400000 * k),
                        k[0] ? sfpa_pkg::t_range'('1) : sfpa_pkg::t_range'('0));
        end
        for (k = 0; k < sfpa_pkg::FRAME_LEN; k++) begin
            send_sample(ANGLE_TOP - sfpa_pkg::t_angle'(400000 * k),
                        sfpa_pkg::t_range'(16'hFFFF - k));
        end
        for (k = 0; k < sfpa_pkg::FRAME_LEN; k++) begin
            send_sample(sfpa_pkg::t_angle'(1800000), sfpa_pkg::t_range'(k * 7 + 1));
        end
    endtask

    // Mostly whole sweeps with random content, some broken runs
    task automatic test_random_frames(input int target);
        while (samples_sent < target) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_frame(t_sweep'($urandom_range(0, 3)));
        end
    endtask

    // Sender stops mid-frame and after frames until the store drains
    task automatic test_drain_pause();
        repeat (3) begin
            send_noise();
            wait_frames_drained();
            send_frame(SWEEP_DOWN);
            wait_frames_drained();
        end
    endtask

    // No idling either side: closing beats meet the previous readout
    task automatic test_back_to_back(input int target);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (samples_sent < target) begin
            send_frame(t_sweep'($urandom_range(0, 3)));
        end
    endtask

    // Receiver stall bursts
    initial begin : rx_stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        sfpa_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_beats_q.size() == 0) begin
                if (err_count < MAX_REPORTS) $error("output beat with no frame pending");
                err_count++;
            end else begin
                want = frame_beats_q.pop_front();
                if (o_res != want) err_count++;
                if (err_count < MAX_REPORTS) begin
                    if (o_res.range_out != want.range_out)
                        $error("range_out: expected %0d, got %0d",
                               want.range_out, o_res.range_out);
                    if (o_res.slot_index != want.slot_index)
                        $error("slot_index: expected %0d, got %0d",
                               want.slot_index, o_res.slot_index);
                    if (o_res.frame_start_angle != want.frame_start_angle)
                        $error("frame_start_angle: expected %0d, got %0d",
                               want.frame_start_angle, o_res.frame_start_angle);
                    if (o_res.frame_stop_angle != want.frame_stop_angle)
                        $error("frame_stop_angle: expected %0d, got %0d",
                               want.frame_stop_angle, o_res.frame_stop_angle);
                    if (o_res.frame_last != want.frame_last)
                        $error("frame_last: expected %0d, got %0d",
                               want.frame_last, o_res.frame_last);
                end
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_run = 0;
            else idle_run++;
        end
        $display("tb_scan_frame_pingpong_assembler_core failed");
        $finish;
    end

    initial begin : main_seq
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_sweeps();
        test_random_frames(220);
        test_drain_pause();
        test_back_to_back(360);
        wait_frames_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && frame_beats_q.size() == 0) begin
            $display("tb_scan_frame_pingpong_assembler_core passed");
        end else begin
            $display("tb_scan_frame_pingpong_assembler_core failed");
        end
        $finish;
    end

endmodule
